// ===== sv/ame_pkg.sv =====
// Shared types and constants of the accumulator machine execute unit.
// Used by every module of the block; depends on nothing else.
package ame_pkg;

    localparam int DEF_MEM_DEPTH  = 256;
    localparam int DEF_DATA_WIDTH = 32;

    // Stream widths: tdata is padded to whole bytes.
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 80;
    localparam int M_TUSER_W = 2;

    // Depth of the queue between the decode front and the execute back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        OP_LDM     = 5'd0,
        OP_LDD     = 5'd1,
        OP_LDX     = 5'd2,
        OP_LDR     = 5'd3,
        OP_STO     = 5'd4,
        OP_STX     = 5'd5,
        OP_ADD     = 5'd6,
        OP_INC     = 5'd7,
        OP_DEC     = 5'd8,
        OP_JMP     = 5'd9,
        OP_CMP     = 5'd10,
        OP_JPE     = 5'd11,
        OP_JPN     = 5'd12,
        OP_IN      = 5'd13,
        OP_OUT     = 5'd14,
        OP_LSL     = 5'd15,
        OP_LSR     = 5'd16,
        OP_AND     = 5'd17,
        OP_XOR     = 5'd18,
        OP_OR      = 5'd19,
        OP_END     = 5'd20,
        OP_PRELOAD = 5'd21
    } op_t;

    typedef enum logic [1:0] {
        CMP_LESS    = 2'd0,
        CMP_EQUAL   = 2'd1,
        CMP_GREATER = 2'd2
    } cmp_t;

    // One classified instruction as it waits in the queue.
    typedef struct packed {
        op_t         op;
        logic        err;
        logic        use_imm;
        logic [31:0] imm;
        logic [7:0]  addr;
        logic [7:0]  target;
        logic        sel_ix;
        logic [7:0]  in_byte;
    } dec_t;

    // One result beat as the execute back hands it to the output port.
    typedef struct packed {
        logic [31:0] acc;
        logic [31:0] ix;
        cmp_t        cmp;
        logic        taken;
        logic [7:0]  target;
        logic        outv;
        logic        halt;
        logic        err;
    } res_t;

endpackage

// ===== sv/ame_front.sv =====
// Decode front: unpacks an input beat and checks the operand kind against the opcode.
// Depends on ame_pkg.
module ame_front import ame_pkg::*; (
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,
    output dec_t                 item
);

    logic [4:0] func;

    assign func = s_tdata[4:0];

    always_comb begin
        item.op      = op_t'(func);
        item.use_imm = s_tuser;
        item.imm     = s_tdata[36:5];
        item.addr    = s_tdata[44:37];
        item.target  = s_tdata[52:45];
        item.sel_ix  = s_tdata[53];
        item.in_byte = s_tdata[61:54];
        unique case (item.op) inside
            OP_LDM, OP_LDR, OP_LSL, OP_LSR: begin
                item.err = !s_tuser;
            end
            OP_LDD, OP_LDX, OP_STO, OP_STX, OP_INC, OP_DEC, OP_JMP, OP_JPE, OP_JPN: begin
                item.err = s_tuser;
            end
            OP_ADD, OP_CMP, OP_IN, OP_OUT, OP_AND, OP_XOR, OP_OR, OP_END, OP_PRELOAD: begin
                item.err = 1'b0;
            end
            default: begin
                // Opcodes past the preload code are not defined.
                item.err = 1'b1;
            end
        endcase
    end

endmodule

// ===== sv/ame_queue.sv =====
// Short FIFO that decouples the decode front from the execute back.
// Depends on ame_pkg for the entry type and depth.
module ame_queue import ame_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  dec_t push_item,
    output logic pop_valid,
    input  logic pop,
    output dec_t pop_item
);

    dec_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop_fire;

    assign push_ready = count_reg != QCNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop_fire   = pop && pop_valid;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop_fire) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop_fire) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop_fire && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/ame_back.sv =====
// Execute back: index register and memory read at issue, accumulator, compare flag,
// stores and the output register at execute. Depends on ame_pkg.
module ame_back import ame_pkg::*; #(
    parameter int MEM_DEPTH  = DEF_MEM_DEPTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic q_valid,
    input  dec_t q_item,
    output logic q_pop,
    input  logic out_ready,
    output logic out_valid,
    output res_t out_res,
    output logic init_done
);

    // MEM_DEPTH is taken as a power of two, so address wrap is a truncation.
    localparam int AW = $clog2(MEM_DEPTH);
    localparam int SW = $clog2(DATA_WIDTH);

    logic [DATA_WIDTH-1:0] mem [MEM_DEPTH];

    logic                  clr_done_reg;
    logic [AW-1:0]         clr_addr_reg;

    logic [DATA_WIDTH-1:0] ix_reg;
    logic [DATA_WIDTH-1:0] ix_next;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic [DATA_WIDTH-1:0] acc_next;
    cmp_t                  cmp_reg;
    cmp_t                  cmp_next;

    logic                  e_valid_reg;
    dec_t                  e_item_reg;
    logic [DATA_WIDTH-1:0] e_ix_reg;
    logic [AW-1:0]         e_addr_reg;
    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  fwd_hit_reg;
    logic [DATA_WIDTH-1:0] fwd_data_reg;

    logic                  out_valid_reg;
    res_t                  res_reg;
    res_t                  res_next;

    logic                  out_free;
    logic                  e_fire;
    logic [DATA_WIDTH-1:0] q_imm;
    logic [AW-1:0]         pop_addr;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  e_store;

    logic [DATA_WIDTH-1:0] e_imm;
    logic [DATA_WIDTH-1:0] mem_q;
    logic [DATA_WIDTH-1:0] opnd;
    logic [SW-1:0]         sh_amt;
    logic                  sh_big;
    logic                  taken;
    logic                  outv;
    logic                  halt;

    assign init_done = clr_done_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign e_fire    = e_valid_reg && out_free;
    assign q_pop     = q_valid && clr_done_reg && (!e_valid_reg || out_free);
    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

    // Issue: the index register is settled here so that indexed addresses see it at once.
    assign q_imm = DATA_WIDTH'($signed(q_item.imm));

    always_comb begin
        ix_next = ix_reg;
        if (q_pop && !q_item.err) begin
            if (q_item.op == OP_LDR) begin
                ix_next = q_imm;
            end else if (q_item.op == OP_INC && q_item.sel_ix) begin
                ix_next = ix_reg + 1'b1;
            end else if (q_item.op == OP_DEC && q_item.sel_ix) begin
                ix_next = ix_reg - 1'b1;
            end
        end
        if (q_item.op == OP_LDX || q_item.op == OP_STX) begin
            pop_addr = AW'(q_item.addr) + AW'($signed(ix_reg));
        end else begin
            pop_addr = AW'(q_item.addr);
        end
    end

    // Memory write port: the clearing pass after reset, then stores and preloads.
    assign e_store = e_item_reg.op == OP_STO || e_item_reg.op == OP_STX
                     || e_item_reg.op == OP_PRELOAD;

    always_comb begin
        if (!clr_done_reg) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end else begin
            mem_we    = e_fire && !e_item_reg.err && e_store;
            mem_waddr = e_addr_reg;
            mem_wdata = (e_item_reg.op == OP_PRELOAD) ? e_imm : acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (q_pop) begin
            rd_data_reg <= mem[pop_addr];
        end
    end

    // Execute: a store in the same cycle as the read of its address is forwarded.
    assign e_imm  = DATA_WIDTH'($signed(e_item_reg.imm));
    assign mem_q  = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign opnd   = e_item_reg.use_imm ? e_imm : mem_q;
    assign sh_amt = e_item_reg.imm[SW-1:0];
    assign sh_big = e_item_reg.imm >= 32'(DATA_WIDTH);

    always_comb begin
        acc_next = acc_reg;
        cmp_next = cmp_reg;
        taken    = 1'b0;
        outv     = 1'b0;
        halt     = 1'b0;
        if (!e_item_reg.err) begin
            case (e_item_reg.op)
                OP_LDM: acc_next = e_imm;
                OP_LDD, OP_LDX: acc_next = mem_q;
                OP_ADD: acc_next = acc_reg + opnd;
                OP_INC: begin
                    if (!e_item_reg.sel_ix) begin
                        acc_next = acc_reg + 1'b1;
                    end
                end
                OP_DEC: begin
                    if (!e_item_reg.sel_ix) begin
                        acc_next = acc_reg - 1'b1;
                    end
                end
                OP_JMP: taken = 1'b1;
                OP_CMP: begin
                    if ($signed(acc_reg) > $signed(opnd)) begin
                        cmp_next = CMP_GREATER;
                    end else if (acc_reg == opnd) begin
                        cmp_next = CMP_EQUAL;
                    end else begin
                        cmp_next = CMP_LESS;
                    end
                end
                OP_JPE: taken = cmp_reg == CMP_EQUAL;
                OP_JPN: taken = cmp_reg != CMP_EQUAL;
                OP_IN:  acc_next = DATA_WIDTH'(e_item_reg.in_byte);
                OP_OUT: outv = 1'b1;
                OP_LSL: acc_next = sh_big ? '0 : (acc_reg << sh_amt);
                OP_LSR: begin
                    if (sh_big) begin
                        acc_next = {DATA_WIDTH{acc_reg[DATA_WIDTH-1]}};
                    end else begin
                        acc_next = DATA_WIDTH'($signed(acc_reg) >>> sh_amt);
                    end
                end
                OP_AND: acc_next = acc_reg & opnd;
                OP_XOR: acc_next = acc_reg ^ opnd;
                OP_OR:  acc_next = acc_reg | opnd;
                OP_END: halt = 1'b1;
                default: ;
            endcase
        end
        res_next.acc    = 32'($signed(acc_next));
        res_next.ix     = 32'($signed(e_ix_reg));
        res_next.cmp    = cmp_next;
        res_next.taken  = taken;
        res_next.target = taken ? e_item_reg.target : 8'd0;
        res_next.outv   = outv;
        res_next.halt   = halt;
        res_next.err    = e_item_reg.err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_done_reg  <= 1'b0;
            clr_addr_reg  <= '0;
            ix_reg        <= '0;
            acc_reg       <= '0;
            cmp_reg       <= CMP_LESS;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (!clr_done_reg) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(MEM_DEPTH - 1)) begin
                    clr_done_reg <= 1'b1;
                end
            end
            ix_reg <= ix_next;
            if (q_pop) begin
                e_valid_reg <= 1'b1;
            end else if (e_fire) begin
                e_valid_reg <= 1'b0;
            end
            if (e_fire) begin
                acc_reg       <= acc_next;
                cmp_reg       <= cmp_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            e_item_reg   <= q_item;
            e_ix_reg     <= ix_next;
            e_addr_reg   <= pop_addr;
            fwd_hit_reg  <= mem_we && (mem_waddr == pop_addr);
            fwd_data_reg <= mem_wdata;
        end
        if (e_fire) begin
            res_reg <= res_next;
        end
    end

endmodule

// ===== sv/accumulator_machine_execute_top.sv =====
// Top level of the accumulator machine execute unit: decode front, queue, execute back.
// Depends on ame_pkg, ame_front, ame_queue and ame_back.
//
// Channel  Direction  Fields (lowest bit first)
// s_       in         tdata: func, immediate, address, jump_target_in, select_index,
//                     in_byte; tuser: use_immediate
// m_       out        tdata: acc_value, index_value, compare_state, jump_taken,
//                     jump_target; tuser: out_valid, error; tlast: halted
//
// One instruction per cycle is sustained while m_tready stays high; from input to output a beat
// passes the queue, the memory read at issue and execute into the output register.
// After reset a clearing pass writes zero to every memory word, one a cycle; s_tready stays low until it ends.
// The queue absorbs two beats, so input is still taken while a result waits on m_tready, until the queue is full.
module accumulator_machine_execute_top import ame_pkg::*; #(
    parameter int MEM_DEPTH  = DEF_MEM_DEPTH,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // func, immediate, address, jump_target_in,
                                           // select_index, in_byte, zero pad
    input  logic                 s_tuser,  // use_immediate
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // acc_value, index_value, compare_state,
                                           // jump_taken, jump_target, zero pad
    output logic [M_TUSER_W-1:0] m_tuser,  // out_valid, error
    output logic                 m_tlast   // halted
);

    dec_t front_item;
    dec_t q_item;
    logic q_push_ready;
    logic q_valid;
    logic q_pop;
    logic init_done;
    res_t res;

    assign s_tready = q_push_ready && init_done;

    ame_front u_front (
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .item    (front_item)
    );

    ame_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_tvalid && init_done),
        .push_ready (q_push_ready),
        .push_item  (front_item),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_item)
    );

    ame_back #(
        .MEM_DEPTH  (MEM_DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_res   (res),
        .init_done (init_done)
    );

    assign m_tdata = {5'd0, res.target, res.taken, res.cmp, res.ix, res.acc};
    assign m_tuser = {res.err, res.outv};
    assign m_tlast = res.halt;

endmodule

// ===== sv/ame_sva.sv =====
// Port-level checks of the accumulator machine execute unit, bound to the top level.
// Depends on ame_pkg for the stream widths.
module ame_sva import ame_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [M_TUSER_W-1:0] m_tuser,
    input logic                 m_tlast
);

    // A stalled result beat keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Reset empties the output and starts the memory clearing pass.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid && !s_tready)
        else $error("block active right after reset");

    // A rejected instruction neither jumps, outputs nor halts.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> !m_tdata[66] && !m_tuser[0] && !m_tlast)
        else $error("error beat carries an action");

    // The jump target is zero unless the jump is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[66] |-> m_tdata[74:67] == 8'd0)
        else $error("jump target without a taken jump");

endmodule

bind accumulator_machine_execute_top ame_sva u_sva (.*);

// ===== test/accumulator_machine_execute_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench for accumulator_machine_execute_top: streams decoded instructions into s_ and
// checks every m_ result beat against a shadow copy of the machine state kept in the bench.
// Depends on ame_pkg and the RTL of the block.
module accumulator_machine_execute_top_tb;
    import ame_pkg::*;

    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int RANDOM_PER_PHASE = 290;
    localparam int NUM_PHASES       = 5;
    localparam int MAX_REPORTS      = 10;

    // Opcodes past the preload code are not decoded and must flag an error.
    localparam logic [4:0] OP_UNDEF_LO = 5'd22;
    localparam logic [4:0] OP_UNDEF_HI = 5'd31;

    typedef struct packed {
        logic [4:0]  func;
        logic        use_imm;
        logic [31:0] imm;
        logic [7:0]  addr;
        logic [7:0]  target;
        logic        sel_ix;
        logic [7:0]  in_byte;
    } instr_t;

    class exec_scoreboard;
        logic [31:0] acc;
        logic [31:0] ix;
        cmp_t        flag;
        logic [31:0] mem [256];
        res_t        pending_results [$];
        int          mismatches;

        function new();
            acc        = '0;
            ix         = '0;
            flag       = CMP_LESS;
            mismatches = 0;
            foreach (mem[i]) mem[i] = '0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Executes one accepted instruction on the shadow state and queues its result.
        function void issue_instr(instr_t it);
            logic [31:0] opnd;
            logic [7:0]  ix_addr;
            logic        shift_oor;
            res_t        r;
            r = '0;
            case (it.func)
                OP_LDM, OP_LDR, OP_LSL, OP_LSR: r.err = !it.use_imm;
                OP_LDD, OP_LDX, OP_STO, OP_STX, OP_INC, OP_DEC, OP_JMP, OP_JPE, OP_JPN:
                    r.err = it.use_imm;
                default: r.err = (it.func > OP_PRELOAD);
            endcase
            opnd = it.use_imm ? it.imm : mem[it.addr];
            // The indexed address wraps modulo the depth, so only the low index byte counts.
            ix_addr   = it.addr + ix[7:0];
            shift_oor = ($signed(it.imm) < 0) || ($signed(it.imm) > 31);
            if (!r.err) begin
                case (it.func)
                    OP_LDM:     acc = it.imm;
                    OP_LDD:     acc = mem[it.addr];
                    OP_LDX:     acc = mem[ix_addr];
                    OP_LDR:     ix = it.imm;
                    OP_STO:     mem[it.addr] = acc;
                    OP_STX:     mem[ix_addr] = acc;
                    OP_ADD:     acc = acc + opnd;
                    OP_INC: begin
                        if (it.sel_ix) ix = ix + 1;
                        else acc = acc + 1;
                    end
                    OP_DEC: begin
                        if (it.sel_ix) ix = ix - 1;
                        else acc = acc - 1;
                    end
                    OP_JMP:     r.taken = 1'b1;
                    OP_CMP: begin
                        if ($signed(acc) > $signed(opnd)) flag = CMP_GREATER;
                        else if (acc == opnd) flag = CMP_EQUAL;
                        else flag = CMP_LESS;
                    end
                    OP_JPE:     r.taken = (flag == CMP_EQUAL);
                    OP_JPN:     r.taken = (flag != CMP_EQUAL);
                    OP_IN:      acc = {24'd0, it.in_byte};
                    OP_OUT:     r.outv = 1'b1;
                    OP_LSL:     acc = shift_oor ? 32'd0 : acc << it.imm[4:0];
                    OP_LSR: begin
                        if (shift_oor) acc = {32{acc[31]}};
                        else acc = $signed(acc) >>> it.imm[4:0];
                    end
                    OP_AND:     acc = acc & opnd;
                    OP_XOR:     acc = acc ^ opnd;
                    OP_OR:      acc = acc | opnd;
                    OP_END:     r.halt = 1'b1;
                    OP_PRELOAD: mem[it.addr] = it.imm;
                    default: ;
                endcase
            end
            r.acc    = acc;
            r.ix     = ix;
            r.cmp    = flag;
            r.target = r.taken ? it.target : 8'd0;
            pending_results.push_back(r);
        endfunction

        function void check_result(res_t got);
            res_t  want;
            string bad;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result beat with no instruction outstanding (acc=%h)",
                             $time, got.acc);
                return;
            end
            want = pending_results.pop_front();
            bad  = "";
            if (got.acc !== want.acc)       bad = {bad, " acc_value"};
            if (got.ix !== want.ix)         bad = {bad, " index_value"};
            if (got.cmp !== want.cmp)       bad = {bad, " compare_state"};
            if (got.taken !== want.taken)   bad = {bad, " jump_taken"};
            if (got.target !== want.target) bad = {bad, " jump_target"};
            if (got.outv !== want.outv)     bad = {bad, " out_valid"};
            if (got.halt !== want.halt)     bad = {bad, " halted"};
            if (got.err !== want.err)       bad = {bad, " error"};
            if (bad != "") begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: mismatch in%s", $time, bad);
                    $display("  expected acc=%h ix=%h cmp=%0d jmp=%b tgt=%0d out=%b halt=%b err=%b",
                             want.acc, want.ix, want.cmp, want.taken, want.target, want.outv,
                             want.halt, want.err);
                    $display("  actual   acc=%h ix=%h cmp=%0d jmp=%b tgt=%0d out=%b halt=%b err=%b",
                             got.acc, got.ix, got.cmp, got.taken, got.target, got.outv,
                             got.halt, got.err);
                end
            end
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int idle_cycles    = 0;
    int phase_idle  [NUM_PHASES] = '{0, 79, 0, 25, 0};
    int phase_stall [NUM_PHASES] = '{0, 0, 79, 25, 0};
    logic [31:0] extremes [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};

    exec_scoreboard sb = new();

    accumulator_machine_execute_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin : monitor
        res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.acc    = m_tdata[31:0];
            got.ix     = m_tdata[63:32];
            got.cmp    = cmp_t'(m_tdata[65:64]);
            got.taken  = m_tdata[66];
            got.target = m_tdata[74:67];
            got.outv   = m_tuser[0];
            got.err    = m_tuser[1];
            got.halt   = m_tlast;
            sb.check_result(got);
        end
        // The count also covers the memory clearing pass after reset.
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("** accumulator_machine_execute_top: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic instr_t mk(logic [4:0] func, logic use_imm, logic [31:0] imm = '0,
                                  logic [7:0] addr = '0, logic [7:0] target = '0,
                                  logic sel_ix = 1'b0, logic [7:0] in_byte = '0);
        instr_t it;
        it.func    = func;
        it.use_imm = use_imm;
        it.imm     = imm;
        it.addr    = addr;
        it.target  = target;
        it.sel_ix  = sel_ix;
        it.in_byte = in_byte;
        return it;
    endfunction

    // Mostly well-formed instructions on a small set of addresses, so that stores and
    // loads meet; a few wrong operand kinds, undecoded opcodes and raw noise.
    function automatic instr_t random_instr();
        instr_t it;
        int     pick;
        it.func    = 5'($urandom_range(0, OP_PRELOAD));
        it.addr    = ($urandom_range(0, 1) == 1) ? 8'($urandom_range(0, 15)) : 8'($urandom);
        it.target  = 8'($urandom);
        it.sel_ix  = 1'($urandom);
        it.in_byte = 8'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 45) it.imm = $urandom;
        else if (pick < 70) it.imm = 32'($urandom_range(0, 80)) - 32'd40;
        else if (pick < 85) it.imm = extremes[$urandom_range(0, 3)];
        else it.imm = sb.acc;  // lands compares on the equal outcome
        case (it.func)
            OP_LDM, OP_LDR: it.use_imm = 1'b1;
            OP_LSL, OP_LSR: begin
                it.use_imm = 1'b1;
                if ($urandom_range(0, 9) != 0) it.imm = 32'($urandom_range(0, 31));
            end
            OP_LDD, OP_LDX, OP_STO, OP_STX, OP_INC, OP_DEC, OP_JMP, OP_JPE, OP_JPN:
                it.use_imm = 1'b0;
            default: it.use_imm = 1'($urandom);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 5) it.use_imm = ~it.use_imm;
        else if (pick < 8) it.func = 5'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
        else if (pick < 10) it = instr_t'(63'({$urandom, $urandom}));
        return it;
    endfunction

    task automatic send_instr(instr_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, it.in_byte, it.sel_ix, it.target, it.addr, it.imm, it.func};
        s_tuser  <= it.use_imm;
        do @(posedge aclk); while (!s_tready);
        sb.issue_instr(it);
    endtask

    // Holds the input off until every outstanding result beat has been checked.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    initial begin
        instr_t directed [$];
        directed = '{
            mk(OP_LDM, 1'b1, 32'h7FFF_FFFF),
            mk(OP_STO, 1'b0, '0, 8'hFF),
            mk(OP_ADD, 1'b1, 32'd1),
            mk(OP_ADD, 1'b0, '0, 8'hFF),
            mk(OP_LDR, 1'b1, 32'hFFFF_FFFF),
            mk(OP_LDX, 1'b0, '0, 8'h00),             // negative index wraps below zero
            mk(OP_STX, 1'b0, '0, 8'h01),
            mk(OP_INC, 1'b0, '0, '0, '0, 1'b1),
            mk(OP_DEC, 1'b0, '0, '0, '0, 1'b0),
            mk(OP_PRELOAD, 1'b0, 32'd5, 8'd9),
            mk(OP_LDM, 1'b1, 32'd5),
            mk(OP_CMP, 1'b0, '0, 8'd9),
            mk(OP_JPE, 1'b0, '0, '0, 8'hFF),
            mk(OP_JPN, 1'b0, '0, '0, 8'h01),
            mk(OP_CMP, 1'b1, 32'h8000_0000),
            mk(OP_JPN, 1'b0, '0, '0, 8'hAA),
            mk(OP_JMP, 1'b0, '0, '0, 8'h55),
            mk(OP_IN, 1'b1, '0, '0, '0, 1'b0, 8'hFF),
            mk(OP_LSL, 1'b1, 32'd31),
            mk(OP_LSR, 1'b1, 32'd31),
            mk(OP_LSR, 1'b1, 32'hFFFF_FFFF),         // negative amount fills with the sign
            mk(OP_LSL, 1'b1, 32'd32),
            mk(OP_XOR, 1'b1, 32'hFFFF_FFFF),
            mk(OP_AND, 1'b0, '0, 8'hFF),
            mk(OP_OR, 1'b1, 32'h0000_00F0),
            mk(OP_OUT, 1'b0),
            mk(OP_END, 1'b1),
            mk(OP_LDM, 1'b0, 32'd1),
            mk(OP_LDD, 1'b1, '0, 8'd9),
            mk(OP_UNDEF_LO, 1'b1),
            mk(OP_UNDEF_HI, 1'b0)
        };
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed[i]) send_instr(directed[i]);
        drain();
        for (int p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            repeat (RANDOM_PER_PHASE) send_instr(random_instr());
            drain();
        end
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0) begin
            $display("** accumulator_machine_execute_top: PASSED **");
        end else begin
            $display("** accumulator_machine_execute_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== accumulator_machine_execute_top.f =====
sv/ame_pkg.sv
sv/ame_front.sv
sv/ame_queue.sv
sv/ame_back.sv
sv/accumulator_machine_execute_top.sv
sv/ame_sva.sv
test/accumulator_machine_execute_top_tb.sv
